### rtl/rrp_pkg.sv
// ---------------------------------------------------------------------------
// rrp_pkg
// Shared types, codes and immediate field packers for the relocation patcher.
// ---------------------------------------------------------------------------
package rrp_pkg;

  localparam int PCREL_ENTRIES_DEF = 16;

  localparam logic [5:0] MODE_BRANCH     = 6'd16;
  localparam logic [5:0] MODE_CALL       = 6'd18;
  localparam logic [5:0] MODE_CALL_PLT   = 6'd19;
  localparam logic [5:0] MODE_PCREL_HI20 = 6'd23;
  localparam logic [5:0] MODE_PCREL_LO12 = 6'd24;
  localparam logic [5:0] MODE_HI20       = 6'd26;
  localparam logic [5:0] MODE_LO12_I     = 6'd27;
  localparam logic [5:0] MODE_RVC_BRANCH = 6'd44;
  localparam logic [5:0] MODE_RVC_JUMP   = 6'd45;

  localparam logic CFG_TEXT_BASE = 1'b0;
  localparam logic CFG_CODE_END  = 1'b1;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_SKIPPED = 3'd1,
    ST_RANGE   = 3'd2,
    ST_OUTSIDE = 3'd3,
    ST_BADTYPE = 3'd4,
    ST_NOHI    = 3'd5,
    ST_FULL    = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    KIND_PLAIN = 2'd0,
    KIND_PHI   = 2'd1,
    KIND_PLO   = 2'd2
  } kind_t;

  // classified item handed from front to back
  typedef struct packed {
    kind_t        kind;
    logic [31:0]  key;
    logic         win_ok;
    logic [11:0]  lo_new;
    logic [31:0]  first;
    logic [31:0]  pf;
    logic [31:0]  ps;
    logic [1:0]   words;
    logic [31:0]  offset;
    logic [33:0]  cv;
    status_t      status;
  } item_t;

  function automatic logic [31:0] put_b(input logic [31:0] w, input logic [33:0] u);
    logic [31:0] r;
    r = w & ~32'hfe000f80;
    r[31]    = u[12];
    r[30:25] = u[10:5];
    r[11:8]  = u[4:1];
    r[7]     = u[11];
    return r;
  endfunction

  function automatic logic [31:0] put_cb(input logic [31:0] w, input logic [33:0] u);
    logic [31:0] r;
    r = w & ~32'h00001c7c;
    r[12]    = u[8];
    r[11:10] = u[4:3];
    r[6:5]   = u[7:6];
    r[4:3]   = u[2:1];
    r[2]     = u[5];
    return r;
  endfunction

  function automatic logic [31:0] put_cj(input logic [31:0] w, input logic [33:0] u);
    logic [31:0] r;
    r = w & ~32'h00001ffc;
    r[12]  = u[11];
    r[11]  = u[4];
    r[10:9] = u[9:8];
    r[8]   = u[10];
    r[7]   = u[6];
    r[6]   = u[7];
    r[5:3] = u[3:1];
    r[2]   = u[5];
    return r;
  endfunction

  function automatic logic [31:0] put_i(input logic [31:0] w, input logic [11:0] lo);
    return {lo, w[19:0]};
  endfunction

  function automatic logic [31:0] put_u(input logic [31:0] w, input logic [19:0] hi);
    return {hi, w[11:0]};
  endfunction

endpackage

### rtl/rrp_front.sv
// ---------------------------------------------------------------------------
// rrp_front
// Registers an incoming relocation, computes values, checks and patches.
// ---------------------------------------------------------------------------
module rrp_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [5:0]           mode,
  input  logic [31:0]          sym_addr,
  input  logic signed [31:0]   addend,
  input  logic [31:0]          position,
  input  logic                 symbol_in_code,
  input  logic [31:0]          insn_first,
  input  logic [31:0]          insn_second,
  input  logic [31:0]          text_base,
  input  logic [31:0]          code_end,
  output logic                 q_push,
  input  logic                 q_full,
  output rrp_pkg::item_t       q_item
);
  import rrp_pkg::*;

  logic        vld;
  logic [5:0]  r_mode;
  logic [31:0] r_s, r_a, r_p, r_f1, r_f2;
  logic        r_inc;

  logic [33:0] rel, absv, rel_rnd, abs_rnd;
  logic        w2, w4, w8, fit9, fit12, fit13, fit32, hi_rel_ok, hi_abs_ok;
  item_t       it;

  assign in_stall = vld && q_full;
  assign q_push   = vld && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (!in_stall) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      r_mode <= mode;
      r_s    <= sym_addr;
      r_a    <= addend;
      r_p    <= position;
      r_inc  <= symbol_in_code;
      r_f1   <= insn_first;
      r_f2   <= insn_second;
    end
  end

  function automatic logic win(input logic [31:0] p, input logic [31:0] b,
                               input logic [31:0] e, input logic [3:0] n);
    return (p >= b) && (({1'b0, p} + {29'd0, n}) <= {1'b0, e});
  endfunction

  always_comb begin
    absv    = {2'b00, r_s} + {{2{r_a[31]}}, r_a};
    rel     = absv - {2'b00, r_p};
    rel_rnd = rel + 34'h800;
    abs_rnd = absv + 34'h800;
    w2 = win(r_p, text_base, code_end, 4'd2);
    w4 = win(r_p, text_base, code_end, 4'd4);
    w8 = win(r_p, text_base, code_end, 4'd8);
    fit9  = (rel[33:8] == {26{rel[8]}});
    fit12 = (rel[33:11] == {23{rel[11]}});
    fit13 = (rel[33:12] == {22{rel[12]}});
    fit32 = (rel[33:31] == {3{rel[31]}});
    // rounded hi part must fit in signed 20 bits
    hi_rel_ok = (rel_rnd[33:31] == {3{rel_rnd[31]}});
    hi_abs_ok = (abs_rnd[33:31] == {3{abs_rnd[31]}});

    it        = '0;
    it.kind   = KIND_PLAIN;
    it.key    = r_s;
    it.win_ok = w4;
    it.lo_new = rel[11:0];
    it.first  = r_f1;
    it.pf     = r_f1;
    it.ps     = r_f2;
    it.words  = 2'd0;
    it.offset = r_p - text_base;
    it.cv     = '0;
    it.status = ST_OK;

    if (!r_inc) begin
      it.status = ST_SKIPPED;
    end else begin
      case (r_mode)
        MODE_BRANCH: begin
          if (!w4) it.status = ST_OUTSIDE;
          else if (!fit13) it.status = ST_RANGE;
          else begin
            it.pf = put_b(r_f1, rel); it.words = 2'd1; it.cv = rel;
          end
        end
        MODE_RVC_BRANCH: begin
          if (!w2) it.status = ST_OUTSIDE;
          else if (!fit9) it.status = ST_RANGE;
          else begin
            it.pf = put_cb(r_f1, rel); it.words = 2'd1; it.cv = rel;
          end
        end
        MODE_RVC_JUMP: begin
          if (!w2) it.status = ST_OUTSIDE;
          else if (!fit12) it.status = ST_RANGE;
          else begin
            it.pf = put_cj(r_f1, rel); it.words = 2'd1; it.cv = rel;
          end
        end
        MODE_CALL, MODE_CALL_PLT: begin
          if (!w8) it.status = ST_OUTSIDE;
          else if (!fit32 || !hi_rel_ok) it.status = ST_RANGE;
          else begin
            it.pf = put_u(r_f1, rel_rnd[31:12]);
            it.ps = put_i(r_f2, rel[11:0]);
            it.words = 2'd2; it.cv = rel;
          end
        end
        MODE_PCREL_HI20: begin
          it.kind = KIND_PHI;
          it.key  = r_p;
          if (!fit32) it.status = ST_RANGE;
          else if (!w4) it.status = ST_OUTSIDE;
          else if (!hi_rel_ok) it.status = ST_RANGE;
          else begin
            it.pf = put_u(r_f1, rel_rnd[31:12]); it.words = 2'd1; it.cv = rel;
          end
        end
        MODE_PCREL_LO12: begin
          it.kind = KIND_PLO;
        end
        MODE_HI20: begin
          if (!w4) it.status = ST_OUTSIDE;
          else if (!hi_abs_ok) it.status = ST_RANGE;
          else begin
            it.pf = put_u(r_f1, abs_rnd[31:12]); it.words = 2'd1; it.cv = absv;
          end
        end
        MODE_LO12_I: begin
          if (!w4) it.status = ST_OUTSIDE;
          else begin
            it.pf = put_i(r_f1, absv[11:0]); it.words = 2'd1; it.cv = absv;
          end
        end
        default: it.status = ST_BADTYPE;
      endcase
    end
    q_item = it;
  end

endmodule

### rtl/rrp_queue.sv
// ---------------------------------------------------------------------------
// rrp_queue
// Two-entry item queue between front and back.
// ---------------------------------------------------------------------------
module rrp_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  rrp_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output rrp_pkg::item_t head
);
  import rrp_pkg::*;

  item_t       mem [2];
  logic        wptr, rptr;
  logic [1:0]  count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head  = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop)  rptr <= ~rptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= push_item;
  end

endmodule

### rtl/rrp_back.sv
// ---------------------------------------------------------------------------
// rrp_back
// Hi20 table match and update, lo12 patching and the output register.
// ---------------------------------------------------------------------------
module rrp_back #(
  parameter int PCREL_ENTRIES = rrp_pkg::PCREL_ENTRIES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_empty,
  input  rrp_pkg::item_t      q_head,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [31:0]         patched_first,
  output logic [31:0]         patched_second,
  output logic [1:0]          words_written,
  output logic [31:0]         patch_offset,
  output logic signed [33:0]  computed_value,
  output logic [2:0]          status
);
  import rrp_pkg::*;

  localparam int CW = $clog2(PCREL_ENTRIES + 1);

  logic [31:0]         hi_position [PCREL_ENTRIES];
  logic [11:0]         hi_low_part [PCREL_ENTRIES];
  logic [PCREL_ENTRIES-1:0] hi_valid, match, wr_sel;
  logic [CW-1:0]       hi_count;
  logic                hit, tbl_full, do_write;
  logic [11:0]         lo_found;
  item_t               it;

  assign q_pop = !q_empty && (!out_valid || !out_stall);

  always_comb begin
    lo_found = '0;
    for (int i = 0; i < PCREL_ENTRIES; i++) begin
      match[i] = hi_valid[i] && (hi_position[i] == q_head.key);
      if (match[i]) lo_found = lo_found | hi_low_part[i];
    end
    hit      = |match;
    tbl_full = (hi_count == CW'(PCREL_ENTRIES));

    it       = q_head;
    do_write = 1'b0;
    case (q_head.kind)
      KIND_PHI: begin
        if (q_head.status == ST_OK) begin
          if (!hit && tbl_full) begin
            it.status = ST_FULL;
            it.pf     = q_head.first;
            it.words  = 2'd0;
            it.cv     = '0;
          end else begin
            do_write = 1'b1;
          end
        end
      end
      KIND_PLO: begin
        if (!hit) it.status = ST_NOHI;
        else if (!q_head.win_ok) it.status = ST_OUTSIDE;
        else begin
          it.pf    = put_i(q_head.first, lo_found);
          it.words = 2'd1;
          it.cv    = {{22{lo_found[11]}}, lo_found};
        end
      end
      default: ;
    endcase

    // matching entry is rewritten, else the next free one is taken
    for (int i = 0; i < PCREL_ENTRIES; i++) begin
      wr_sel[i] = do_write && (hit ? match[i] : (hi_count == CW'(i)));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hi_valid <= '0;
      hi_count <= '0;
    end else if (q_pop) begin
      hi_valid <= hi_valid | wr_sel;
      if (do_write && !hit) hi_count <= hi_count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < PCREL_ENTRIES; i++) begin
      if (q_pop && wr_sel[i]) begin
        hi_position[i] <= q_head.key;
        hi_low_part[i] <= q_head.lo_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= !q_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      patched_first  <= it.pf;
      patched_second <= it.ps;
      words_written  <= it.words;
      patch_offset   <= it.offset;
      computed_value <= it.cv;
      status         <= it.status;
    end
  end

endmodule

### rtl/riscv_relocation_patcher.sv
// ---------------------------------------------------------------------------
// riscv_relocation_patcher
// Applies one RISC-V relocation per item to the instruction word(s) at P.
// ---------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  in        input      in_valid/in_stall    mode .. insn_second
//  out       output     out_valid/out_stall  patched_first .. status
//  cfg       input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One item per cycle sustained while out_stall stays low. An accepted item sits in
// the front register, moves into the queue and then into the output register,
// where out_valid rises with it.
// Reset clears the hi20 table valid bits and count, the config registers
// and all valid flags. With the output stalled the front keeps accepting
// until the two-entry queue is full and the front register holds an item.
// ---------------------------------------------------------------------------
module riscv_relocation_patcher #(
  parameter int PCREL_ENTRIES = rrp_pkg::PCREL_ENTRIES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [5:0]          mode,
  input  logic [31:0]         sym_addr,
  input  logic signed [31:0]  addend,
  input  logic [31:0]         position,
  input  logic                symbol_in_code,
  input  logic [31:0]         insn_first,
  input  logic [31:0]         insn_second,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [31:0]         patched_first,
  output logic [31:0]         patched_second,
  output logic [1:0]          words_written,
  output logic [31:0]         patch_offset,
  output logic signed [33:0]  computed_value,
  output logic [2:0]          status,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [31:0]         cfg_data
);
  import rrp_pkg::*;

  logic [31:0] text_base, code_end;
  logic        q_push, q_full, q_pop, q_empty;
  item_t       q_in, q_head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_base <= '0;
      code_end  <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_TEXT_BASE: text_base <= cfg_data;
        CFG_CODE_END:  code_end  <= cfg_data;
        default: ;
      endcase
    end
  end

  rrp_front u_front (
    .clk, .rst, .in_valid, .in_stall, .mode, .sym_addr, .addend, .position,
    .symbol_in_code, .insn_first, .insn_second, .text_base, .code_end,
    .q_push, .q_full, .q_item(q_in)
  );

  rrp_queue u_queue (
    .clk, .rst, .push(q_push), .push_item(q_in), .full(q_full),
    .pop(q_pop), .empty(q_empty), .head(q_head)
  );

  rrp_back #(.PCREL_ENTRIES(PCREL_ENTRIES)) u_back (
    .clk, .rst, .q_empty, .q_head, .q_pop, .out_valid, .out_stall,
    .patched_first, .patched_second, .words_written, .patch_offset,
    .computed_value, .status
  );

endmodule

### dv/tb_riscv_relocation_patcher.sv
// ---------------------------------------------------------------------------
// tb_riscv_relocation_patcher
// Drives relocation items into the patcher under random valid/stall gaps,
// predicts each patched word, status and value, and checks results in order.
// ---------------------------------------------------------------------------
import rrp_pkg::*;

typedef struct {
  logic [31:0] pf;
  logic [31:0] ps;
  logic [1:0]  words;
  logic [31:0] offset;
  logic [33:0] cv;
  logic [2:0]  status;
} patch_result_t;

class patch_scoreboard;
  logic [31:0]   text_base;
  logic [31:0]   code_end;
  logic [31:0]   hi_pos[16];
  logic [11:0]   hi_lo[16];
  bit            hi_ok[16];
  int            hi_used;
  patch_result_t pending[$];
  int            errors;
  int            checked;
  int            n_status[8];

  function new();
    text_base = 0;
    code_end = 0;
    hi_used = 0;
    errors = 0;
    checked = 0;
    foreach (hi_ok[i]) hi_ok[i] = 0;
    foreach (n_status[i]) n_status[i] = 0;
  endfunction

  function bit fits(longint v, int bits);
    longint lim;
    lim = longint'(1) << (bits - 1);
    return v >= -lim && v < lim;
  endfunction

  function bit in_win(longint p, longint n);
    return p >= longint'(text_base) && p + n <= longint'(code_end);
  endfunction

  // floor((v + 0x800) / 4096)
  function longint round_hi(longint v);
    return (v + 64'sh800) >>> 12;
  endfunction

  function logic [31:0] ins_b(logic [31:0] w, logic [33:0] u);
    logic [31:0] r;
    r = w & ~32'hfe000f80;
    r[31] = u[12]; r[30:25] = u[10:5]; r[11:8] = u[4:1]; r[7] = u[11];
    return r;
  endfunction

  function logic [31:0] ins_cb(logic [31:0] w, logic [33:0] u);
    logic [31:0] r;
    r = w & ~32'h00001c7c;
    r[12] = u[8]; r[11:10] = u[4:3]; r[6:5] = u[7:6]; r[4:3] = u[2:1]; r[2] = u[5];
    return r;
  endfunction

  function logic [31:0] ins_cj(logic [31:0] w, logic [33:0] u);
    logic [31:0] r;
    r = w & ~32'h00001ffc;
    r[12] = u[11]; r[11] = u[4]; r[10:9] = u[9:8]; r[8] = u[10];
    r[7] = u[6]; r[6] = u[7]; r[5:3] = u[3:1]; r[2] = u[5];
    return r;
  endfunction

  function void note_item(logic [5:0] md, logic [31:0] s, logic [31:0] a, logic [31:0] p,
                          logic inc, logic [31:0] f1, logic [31:0] f2);
    patch_result_t r;
    longint rel, absv, hi, av;
    int slot;
    av = longint'($signed(a));
    rel = longint'(s) + av - longint'(p);
    absv = longint'(s) + av;
    r.pf = f1; r.ps = f2; r.words = 0; r.status = ST_OK; r.cv = 0;
    r.offset = p - text_base;
    slot = -1;
    if (!inc) r.status = ST_SKIPPED;
    else case (md)
      MODE_BRANCH: begin
        if (!in_win(p, 4)) r.status = ST_OUTSIDE;
        else if (!fits(rel, 13)) r.status = ST_RANGE;
        else begin r.pf = ins_b(f1, rel[33:0]); r.words = 1; r.cv = rel[33:0]; end
      end
      MODE_RVC_BRANCH: begin
        if (!in_win(p, 2)) r.status = ST_OUTSIDE;
        else if (!fits(rel, 9)) r.status = ST_RANGE;
        else begin r.pf = ins_cb(f1, rel[33:0]); r.words = 1; r.cv = rel[33:0]; end
      end
      MODE_RVC_JUMP: begin
        if (!in_win(p, 2)) r.status = ST_OUTSIDE;
        else if (!fits(rel, 12)) r.status = ST_RANGE;
        else begin r.pf = ins_cj(f1, rel[33:0]); r.words = 1; r.cv = rel[33:0]; end
      end
      MODE_CALL, MODE_CALL_PLT: begin
        hi = round_hi(rel);
        if (!in_win(p, 8)) r.status = ST_OUTSIDE;
        else if (!fits(rel, 32) || !fits(hi, 20)) r.status = ST_RANGE;
        else begin
          r.pf = {hi[19:0], f1[11:0]};
          r.ps = {rel[11:0], f2[19:0]};
          r.words = 2; r.cv = rel[33:0];
        end
      end
      MODE_PCREL_HI20: begin
        hi = round_hi(rel);
        if (!fits(rel, 32)) r.status = ST_RANGE;
        else if (!in_win(p, 4)) r.status = ST_OUTSIDE;
        else if (!fits(hi, 20)) r.status = ST_RANGE;
        else begin
          for (int i = 0; i < 16; i++)
            if (slot < 0 && hi_ok[i] && hi_pos[i] == p) slot = i;
          if (slot < 0 && hi_used < 16) begin slot = hi_used; hi_used++; end
          if (slot < 0) r.status = ST_FULL;
          else begin
            hi_pos[slot] = p; hi_lo[slot] = rel[11:0]; hi_ok[slot] = 1;
            r.pf = {hi[19:0], f1[11:0]}; r.words = 1; r.cv = rel[33:0];
          end
        end
      end
      MODE_PCREL_LO12: begin
        for (int i = 0; i < 16; i++)
          if (slot < 0 && hi_ok[i] && hi_pos[i] == s) slot = i;
        if (slot < 0) r.status = ST_NOHI;
        else if (!in_win(p, 4)) r.status = ST_OUTSIDE;
        else begin
          r.pf = {hi_lo[slot], f1[19:0]}; r.words = 1;
          r.cv = {{22{hi_lo[slot][11]}}, hi_lo[slot]};
        end
      end
      MODE_HI20: begin
        hi = round_hi(absv);
        if (!in_win(p, 4)) r.status = ST_OUTSIDE;
        else if (!fits(hi, 20)) r.status = ST_RANGE;
        else begin r.pf = {hi[19:0], f1[11:0]}; r.words = 1; r.cv = absv[33:0]; end
      end
      MODE_LO12_I: begin
        if (!in_win(p, 4)) r.status = ST_OUTSIDE;
        else begin r.pf = {absv[11:0], f1[19:0]}; r.words = 1; r.cv = absv[33:0]; end
      end
      default: r.status = ST_BADTYPE;
    endcase
    if (r.status != ST_OK) begin
      r.cv = 0; r.pf = f1; r.ps = f2; r.words = 0;
    end
    pending.push_back(r);
  endfunction

  function void check_result(logic [31:0] pf, logic [31:0] ps, logic [1:0] w,
                             logic [31:0] off, logic [33:0] cv, logic [2:0] st);
    patch_result_t e;
    if (pending.size() == 0) begin
      $error("result with no item pending");
      errors++;
      return;
    end
    e = pending.pop_front();
    checked++;
    n_status[e.status]++;
    if (pf !== e.pf) begin $error("patched_first exp %h got %h", e.pf, pf); errors++; end
    if (ps !== e.ps) begin $error("patched_second exp %h got %h", e.ps, ps); errors++; end
    if (w !== e.words) begin $error("words_written exp %0d got %0d", e.words, w); errors++; end
    if (off !== e.offset) begin $error("patch_offset exp %h got %h", e.offset, off); errors++; end
    if (cv !== e.cv) begin $error("computed_value exp %h got %h", e.cv, cv); errors++; end
    if (st !== e.status) begin $error("status exp %0d got %0d", e.status, st); errors++; end
  endfunction
endclass

module tb_riscv_relocation_patcher;
  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0, in_stall;
  logic [5:0] mode = 0;
  logic [31:0] sym_addr = 0, position = 0, insn_first = 0, insn_second = 0;
  logic signed [31:0] addend = 0;
  logic symbol_in_code = 0;
  logic out_valid, out_stall = 0;
  logic [31:0] patched_first, patched_second, patch_offset;
  logic [1:0] words_written;
  logic signed [33:0] computed_value;
  logic [2:0] status;
  logic cfg_valid = 0, cfg_ready, cfg_index = 0;
  logic [31:0] cfg_data = 0;

  patch_scoreboard sb = new();
  bit quiet = 0;
  logic [31:0] hi_keys[$];
  int n_items = 0;

  riscv_relocation_patcher dut (.*);

  always #10 clk = ~clk;

  // receiver: random stall bursts, none when quiet
  initial begin
    int k;
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        k = $urandom_range(1, 5);
        out_stall <= 1;
        repeat (k) @(posedge clk);
      end
      out_stall <= 0;
    end
  end

  always @(posedge clk)
    if (!rst && out_valid && !out_stall)
      sb.check_result(patched_first, patched_second, words_written, patch_offset,
                      computed_value, status);

  task automatic write_reg(logic idx, logic [31:0] val);
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_TEXT_BASE) sb.text_base = val; else sb.code_end = val;
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic set_window(logic [31:0] b, logic [31:0] e);
    drain();
    write_reg(CFG_TEXT_BASE, b);
    write_reg(CFG_CODE_END, e);
  endtask

  task automatic send(logic [5:0] md, logic [31:0] s, logic [31:0] a, logic [31:0] p,
                      logic inc, logic [31:0] f1, logic [31:0] f2);
    int k;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      k = $urandom_range(1, 5);
      in_valid <= 0;
      repeat (k) @(posedge clk);
    end
    in_valid <= 1; mode <= md; sym_addr <= s; addend <= a; position <= p;
    symbol_in_code <= inc; insn_first <= f1; insn_second <= f2;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_item(md, s, a, p, inc, f1, f2);
    n_items++;
  endtask

  task automatic idle_input();
    in_valid <= 0;
    @(posedge clk);
  endtask

  function automatic logic [5:0] pick_mode();
    logic [5:0] m[9] = '{MODE_BRANCH, MODE_CALL, MODE_CALL_PLT, MODE_PCREL_HI20,
                          MODE_PCREL_LO12, MODE_HI20, MODE_LO12_I, MODE_RVC_BRANCH,
                          MODE_RVC_JUMP};
    if ($urandom_range(0, 15) == 0) return 6'($urandom);
    return m[$urandom_range(0, 8)];
  endfunction

  // mostly in-window positions and near offsets so checks pass deeply
  task automatic random_item(logic [31:0] base, logic [31:0] span);
    logic [5:0] md;
    logic [31:0] p, s, a;
    int r;
    md = pick_mode();
    p = base + ($urandom_range(0, span) & ~32'h1);
    if ($urandom_range(0, 9) == 0) p = $urandom;
    r = $urandom_range(0, 9);
    if (r < 6) s = p + $urandom_range(0, 8191) - 4096;
    else if (r < 8) s = $urandom;
    else s = p + $urandom_range(0, 511) - 256;
    a = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 63) - 32;
    if (md == MODE_PCREL_LO12 && hi_keys.size() > 0 && $urandom_range(0, 3) != 0)
      s = hi_keys[$urandom_range(0, hi_keys.size() - 1)];
    if (md == MODE_PCREL_HI20) hi_keys.push_back(p);
    send(md, s, a, p, $urandom_range(0, 15) != 0, $urandom, $urandom);
  endtask

  initial begin
    #100000000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    logic [31:0] b;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    set_window(32'h1000, 32'h9000);
    // directed: every type, window edges, range edges, extremes
    send(MODE_BRANCH, 32'h2000 + 4094, 0, 32'h2000, 1, 32'hffffffff, 0);
    send(MODE_BRANCH, 32'h2000 - 4096, 0, 32'h2000, 1, 32'h0, 0);
    send(MODE_BRANCH, 32'h2000 + 4096, 0, 32'h2000, 1, 32'h0, 0);
    send(MODE_BRANCH, 32'h2000, 0, 32'h8ffc, 1, 0, 0);
    send(MODE_BRANCH, 32'h2000, 0, 32'h8ffd, 1, 0, 0);
    send(MODE_RVC_BRANCH, 32'h30fe, 0, 32'h3000, 1, 32'hffffffff, 0);
    send(MODE_RVC_BRANCH, 32'h3100, 0, 32'h3000, 1, 0, 0);
    send(MODE_RVC_JUMP, 32'h3000 - 2048, 0, 32'h3000, 1, 32'hffffffff, 0);
    send(MODE_RVC_JUMP, 32'h3000, 0, 32'h8ffe, 1, 0, 0);
    send(MODE_CALL, 32'h7ffff800, 32'h7fffffff, 32'h1000, 1, 32'hffffffff, 32'hffffffff);
    send(MODE_CALL_PLT, 32'h2800, 32'h800, 32'h2000, 1, 0, 0);
    send(MODE_CALL, 32'h2000, 0, 32'h8ffc, 1, 0, 0);
    send(MODE_PCREL_LO12, 32'h4000, 0, 32'h4004, 1, 0, 0);
    send(MODE_PCREL_HI20, 32'h4fff, 32'h80000000, 32'h4000, 1, 0, 0);
    send(MODE_PCREL_HI20, 32'h5800, 0, 32'h4000, 1, 32'hffffffff, 0);
    send(MODE_PCREL_LO12, 32'h4000, 0, 32'h4004, 1, 32'hffffffff, 0);
    send(MODE_PCREL_HI20, 32'h0, 32'h7fffffff, 32'h0, 1, 0, 0);
    send(MODE_HI20, 32'h7ffff7ff, 0, 32'h2000, 1, 0, 0);
    send(MODE_HI20, 32'hffffffff, 32'h7fffffff, 32'h2000, 1, 0, 0);
    send(MODE_LO12_I, 32'hffffffff, 32'h80000000, 32'h2000, 1, 32'hffffffff, 0);
    send(MODE_BRANCH, 32'h2000, 0, 32'h2000, 0, 32'h1234, 32'h5678);
    send(6'h3f, 32'hffffffff, 32'hffffffff, 32'hffffffff, 1, 32'hffffffff, 32'hffffffff);
    send(6'h0, 0, 0, 0, 1, 0, 0);
    // fill the table to see the full case
    for (int i = 0; i < 18; i++) send(MODE_PCREL_HI20, 32'h6000, 0, 32'h5000 + 4 * i, 1, 0, 0);
    idle_input();
    drain(); // sender holds off until everything is back
    // random phases over several windows
    for (int ph = 0; ph < 4; ph++) begin
      idle_input();
      case (ph)
        0: b = 32'h0;
        1: b = $urandom & ~32'h3;
        2: b = 32'hfffff000;
        default: b = 32'h00010000;
      endcase
      if (ph == 2) set_window(b, 32'hffffffff);
      else set_window(b, b + 32'h4000);
      hi_keys.delete();
      repeat (200) random_item(b, 32'h4000);
    end
    idle_input();
    set_window(32'h0, 32'h0);
    quiet = 1;
    repeat (40) random_item(32'h0, 32'h10);
    idle_input();
    drain();
    $display("items sent: %0d, results checked: %0d", n_items, sb.checked);
    $display("status mix ok/skip/range/outside/badtype/nohi/full: %0d %0d %0d %0d %0d %0d %0d",
             sb.n_status[0], sb.n_status[1], sb.n_status[2], sb.n_status[3],
             sb.n_status[4], sb.n_status[5], sb.n_status[6]);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule

### riscv_relocation_patcher.f
rtl/rrp_pkg.sv
rtl/rrp_front.sv
rtl/rrp_queue.sv
rtl/rrp_back.sv
rtl/riscv_relocation_patcher.sv
dv/tb_riscv_relocation_patcher.sv
